[design/life_pkg.sv]
// Shared types and constants for the toroidal Life automaton.
// Used by life_mem, life_rule and toroidal_life_automaton. No dependencies.
package life_pkg;

  // Field widths of the request, result and configuration ports
  localparam int MODE_W     = 2;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 6;
  localparam int ROWS_CFG_W = 6;
  localparam int COLS_CFG_W = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  // Working width for size clamping (holds sizes up to 256)
  localparam int SZ_W = 9;

  // Default grid storage size
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 64;

  // Smallest active size
  localparam int MIN_SIZE = 3;

  // Register reset values
  localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 6'd20;
  localparam logic [COLS_CFG_W-1:0] COLS_RST = 7'd40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_PRIME0,
    ST_PRIME1,
    ST_GEN,
    ST_RESP
  } state_t;

endpackage

[design/toroidal_life_automaton.sv]
// Toroidal Life automaton (B3/S23) top level: request sequencer, row buffers, config.
// Depends on life_pkg, life_mem and life_rule.
// Sequence: an in-range write or read passes through ST_CELL, then ST_RESP; out-of-range
//   and unknown-mode requests go straight to ST_RESP; a step passes through ST_PRIME0,
//   ST_PRIME1 and ST_GEN, one grid row read, updated and written per cycle, then ST_RESP.
// Requests: one at a time; in_stall holds while the sequencer is not idle, and the
//   result is registered from ST_RESP once the output is free.
// Reset: grid reads all dead (row valid bits cleared), rows 20, columns 40, output empty.
module toroidal_life_automaton #(
  parameter int MAX_ROWS = life_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = life_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [life_pkg::MODE_W-1:0]     in_mode,
  input  logic [life_pkg::ROW_W-1:0]      in_row,
  input  logic [life_pkg::COL_W-1:0]      in_col,
  input  logic                            in_cell_in,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_cell_out,
  output logic                            out_out_of_range,
  output logic [life_pkg::MODE_W-1:0]     out_done_mode,
  // configuration
  input  logic                            cfg_we,
  input  logic [life_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [life_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import life_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLS + 1);

  state_t state_r, state_nxt;

  logic [ROWS_CFG_W-1:0] rows_cfg_r;
  logic [COLS_CFG_W-1:0] cols_cfg_r;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              val_r, val_nxt;
  logic              flag_r, flag_nxt;
  logic              res_cell_r, res_cell_nxt;
  logic [NRW-1:0]    rc_r, rc_nxt;

  logic [MAX_COLS-1:0] prev_r, prev_nxt;
  logic [MAX_COLS-1:0] cur_r, cur_nxt;
  logic [MAX_COLS-1:0] first_r, first_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_cell_r, out_cell_nxt;
  logic              out_flag_r, out_flag_nxt;
  logic [MODE_W-1:0] out_mode_r, out_mode_nxt;

  logic [SZ_W-1:0] rows_ext, cols_ext;
  logic [NRW-1:0]  nr;
  logic [NCW-1:0]  nc;
  logic            in_take;
  logic            in_outside;
  logic            out_free;
  logic            gen_last;
  logic            gen_more;

  logic                mem_rd_en, mem_wr_en;
  logic [RW-1:0]       mem_rd_addr, mem_wr_addr;
  logic [MAX_COLS-1:0] mem_rd_data, mem_wr_data;
  logic [MAX_COLS-1:0] below;
  logic [MAX_COLS-1:0] gen_row;
  logic [MAX_COLS-1:0] cell_row;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_RST;
      cols_cfg_r <= COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_cfg_r <= cfg_wdata[ROWS_CFG_W-1:0];
        REG_COLS: cols_cfg_r <= cfg_wdata[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Active size, clamped to 3..MAX
  assign rows_ext = SZ_W'(rows_cfg_r);
  assign cols_ext = SZ_W'(cols_cfg_r);

  always_comb begin
    if (rows_ext < SZ_W'(MIN_SIZE)) begin
      nr = NRW'(MIN_SIZE);
    end else if (rows_ext > SZ_W'(MAX_ROWS)) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_ext);
    end
    if (cols_ext < SZ_W'(MIN_SIZE)) begin
      nc = NCW'(MIN_SIZE);
    end else if (cols_ext > SZ_W'(MAX_COLS)) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_ext);
    end
  end

  // Request handshake and range check
  assign in_stall   = (state_r != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign in_outside = (SZ_W'(in_row) >= SZ_W'(nr)) || (SZ_W'(in_col) >= SZ_W'(nc));
  assign out_free   = !out_valid_r || !out_stall;

  // Generation row counter conditions
  assign gen_last = (rc_r == nr - NRW'(1));
  assign gen_more = ((NRW+1)'(rc_r) + (NRW+1)'(2)) < (NRW+1)'(nr);
  assign below    = gen_last ? first_r : mem_rd_data;

  // Row store
  life_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS),
    .AW   (RW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Next-generation row
  life_rule #(
    .COLS (MAX_COLS),
    .NCW  (NCW)
  ) u_rule (
    .above   (prev_r),
    .cur     (cur_r),
    .below   (below),
    .nc      (nc),
    .nxt_row (gen_row)
  );

  // Single cell replaced in the row just read
  always_comb begin
    cell_row        = mem_rd_data;
    cell_row[col_r] = val_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_mode == MODE_STEP) begin
            state_nxt = ST_PRIME0;
          end else if ((in_mode == MODE_WRITE || in_mode == MODE_READ) && !in_outside) begin
            state_nxt = ST_CELL;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_CELL:   state_nxt = ST_RESP;
      ST_PRIME0: state_nxt = ST_PRIME1;
      ST_PRIME1: state_nxt = ST_GEN;
      ST_GEN: begin
        if (gen_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = row_r;
    mem_wr_data   = cell_row;
    mode_nxt      = mode_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    flag_nxt      = flag_r;
    res_cell_nxt  = res_cell_r;
    rc_nxt        = rc_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cell_nxt  = out_cell_r;
    out_flag_nxt  = out_flag_r;
    out_mode_nxt  = out_mode_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          mode_nxt     = in_mode;
          row_nxt      = RW'(in_row);
          col_nxt      = CW'(in_col);
          val_nxt      = in_cell_in;
          flag_nxt     = (in_mode == MODE_WRITE || in_mode == MODE_READ) && in_outside;
          res_cell_nxt = (in_mode == MODE_WRITE) ? in_cell_in : 1'b0;
          rc_nxt       = '0;
          if (in_mode == MODE_STEP) begin
            // old last row first: it is the row above row 0
            mem_rd_en   = 1'b1;
            mem_rd_addr = RW'(nr - NRW'(1));
          end else if ((in_mode == MODE_WRITE || in_mode == MODE_READ) && !in_outside) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = RW'(in_row);
          end
        end
      end
      ST_CELL: begin
        if (mode_r == MODE_WRITE) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = row_r;
          mem_wr_data = cell_row;
        end else begin
          res_cell_nxt = mem_rd_data[col_r];
        end
      end
      ST_PRIME0: begin
        prev_nxt    = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = '0;
      end
      ST_PRIME1: begin
        first_nxt   = mem_rd_data;
        cur_nxt     = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = RW'(1);
      end
      ST_GEN: begin
        // write row rc, slide the window down, fetch two rows ahead
        mem_wr_en   = 1'b1;
        mem_wr_addr = RW'(rc_r);
        mem_wr_data = gen_row;
        prev_nxt    = cur_r;
        cur_nxt     = below;
        rc_nxt      = rc_r + NRW'(1);
        if (gen_more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = RW'((NRW+1)'(rc_r) + (NRW+1)'(2));
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = res_cell_r;
          out_flag_nxt  = flag_r;
          out_mode_nxt  = mode_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    val_r      <= val_nxt;
    flag_r     <= flag_nxt;
    res_cell_r <= res_cell_nxt;
    rc_r       <= rc_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    first_r    <= first_nxt;
    out_cell_r <= out_cell_nxt;
    out_flag_r <= out_flag_nxt;
    out_mode_r <= out_mode_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_cell_out     = out_cell_r;
  assign out_out_of_range = out_flag_r;
  assign out_done_mode    = out_mode_r;

endmodule

[design/life_mem.sv]
// Row store for the Life grid: one row per entry, registered read.
// Per-row valid bits make never-written rows read as dead. Uses life_pkg.
module life_mem #(
  parameter int ROWS = life_pkg::DEF_MAX_ROWS,
  parameter int COLS = life_pkg::DEF_MAX_COLS,
  parameter int AW   = $clog2(ROWS)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [COLS-1:0] rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [COLS-1:0] wr_data
);
  import life_pkg::*;

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] valid_r;
  logic [COLS-1:0] rd_q_r;
  logic            rd_vld_r;

  // Row storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Row valid bits, cleared at reset so the grid starts all dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[design/life_rule.sv]
// B3/S23 next-state logic for one grid row with horizontal wrap at the active width.
// Columns beyond the active width keep their value. Uses life_pkg.
module life_rule #(
  parameter int COLS = life_pkg::DEF_MAX_COLS,
  parameter int NCW  = $clog2(COLS + 1)
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] cur,
  input  logic [COLS-1:0] below,
  input  logic [NCW-1:0]  nc,
  output logic [COLS-1:0] nxt_row
);
  import life_pkg::*;

  localparam int CW = $clog2(COLS);

  logic [CW-1:0] nc_m1;

  assign nc_m1 = CW'(nc - NCW'(1));

  // One neighbor count and rule per column
  for (genvar c = 0; c < COLS; c++) begin : g_col
    localparam int RC = (c + 1 < COLS) ? c + 1 : 0;
    logic       al, ar, cl, cr, bl, br;
    logic       wrap_r;
    logic [3:0] n;
    logic       active;

    // Left neighbor: column 0 wraps to the last active column
    if (c == 0) begin : g_lwrap
      assign al = above[nc_m1];
      assign cl = cur[nc_m1];
      assign bl = below[nc_m1];
    end else begin : g_lin
      assign al = above[c-1];
      assign cl = cur[c-1];
      assign bl = below[c-1];
    end

    // Right neighbor: last active column wraps to column 0
    assign wrap_r = (CW'(c) == nc_m1);
    assign ar = wrap_r ? above[0] : above[RC];
    assign cr = wrap_r ? cur[0]   : cur[RC];
    assign br = wrap_r ? below[0] : below[RC];

    assign n = 4'(al) + 4'(above[c]) + 4'(ar) + 4'(cl) + 4'(cr)
             + 4'(bl) + 4'(below[c]) + 4'(br);

    assign active = (NCW'(c) < nc);

    // Survive on 2 or 3, born on 3
    assign nxt_row[c] = active ? ((n == 4'd3) || (cur[c] && (n == 4'd2))) : cur[c];
  end

endmodule
